@@ rtl/loop_nest_lane_group_mapper_assert.svh @@
// Assertion macros used by the checker file.
`ifndef LOOP_NEST_LANE_GROUP_MAPPER_ASSERT_SVH
`define LOOP_NEST_LANE_GROUP_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LGM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgm check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LGM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgm check failed");

`endif

@@ rtl/lgm_pkg.sv @@
package lgm_pkg;

    // Field and register widths
    localparam int BW        = 16;   // loop bound width
    localparam int LW        = 7;    // lane count register width
    localparam int MAX_LANES = 64;
    localparam int GW        = 48;   // group index / count width
    localparam int LNW       = 6;    // lane index width
    localparam int FW        = 54;   // flat iteration width
    localparam int C0W       = 17;   // inner coordinate width
    localparam int IDXW      = 3;    // register index width

    // Divider chain geometry
    localparam int XW   = FW;        // dividend / quotient register width
    localparam int NA   = BW;        // steps of the chunk-count divider
    localparam int NB   = XW;        // steps of the first main divider row
    localparam int NC   = XW;        // steps of the second main divider row
    localparam int NSTG = 4 + NA + 1 + NB + 1 + NC;

    typedef enum logic [IDXW-1:0] {
        CFG_INNER   = 3'd0,
        CFG_MIDDLE  = 3'd1,
        CFG_OUTER   = 3'd2,
        CFG_LANES   = 3'd3,
        CFG_FLATTEN = 3'd4
    } cfg_idx_t;

    // Effective configuration (zero bounds and lanes already lifted to one)
    typedef struct packed {
        logic [BW-1:0] b0;
        logic [BW-1:0] b1;
        logic [BW-1:0] b2;
        logic [LW-1:0] lanes;
        logic          flatten;
    } cfg_t;

    // One restoring-division lane as it moves between cells
    typedef struct packed {
        logic [XW-1:0] x;
        logic [BW-1:0] rem;
        logic [BW-1:0] dvs;
    } lgm_div_t;

endpackage

@@ rtl/lgm_cfg_regs.sv @@
module lgm_cfg_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [lgm_pkg::IDXW-1:0] index,
    input  logic [lgm_pkg::BW-1:0]   data,
    output lgm_pkg::cfg_t            cfg
);
    import lgm_pkg::*;

    logic [BW-1:0] inner_reg, inner_next;
    logic [BW-1:0] middle_reg, middle_next;
    logic [BW-1:0] outer_reg, outer_next;
    logic [LW-1:0] lanes_reg, lanes_next;
    logic          flatten_reg, flatten_next;

    // Decode the write
    always_comb
    begin
        inner_next   = inner_reg;
        middle_next  = middle_reg;
        outer_next   = outer_reg;
        lanes_next   = lanes_reg;
        flatten_next = flatten_reg;
        if (we)
        begin
            unique case (index)
                CFG_INNER:   inner_next   = data;
                CFG_MIDDLE:  middle_next  = data;
                CFG_OUTER:   outer_next   = data;
                CFG_LANES:   lanes_next   = data[LW-1:0];
                CFG_FLATTEN: flatten_next = data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg   <= BW'(1);
            middle_reg  <= BW'(1);
            outer_reg   <= BW'(1);
            lanes_reg   <= LW'(1);
            flatten_reg <= 1'b0;
        end
        else
        begin
            inner_reg   <= inner_next;
            middle_reg  <= middle_next;
            outer_reg   <= outer_next;
            lanes_reg   <= lanes_next;
            flatten_reg <= flatten_next;
        end
    end

    // Lift zero to one, saturate the lane count
    always_comb
    begin
        cfg.b0      = (inner_reg == '0)  ? BW'(1) : inner_reg;
        cfg.b1      = (middle_reg == '0) ? BW'(1) : middle_reg;
        cfg.b2      = (outer_reg == '0)  ? BW'(1) : outer_reg;
        cfg.flatten = flatten_reg;
        if (lanes_reg == '0)
            cfg.lanes = LW'(1);
        else if (lanes_reg > LW'(MAX_LANES))
            cfg.lanes = LW'(MAX_LANES);
        else
            cfg.lanes = lanes_reg;
    end

endmodule

@@ rtl/lgm_div_cell.sv @@
module lgm_div_cell (
    input  logic              clk,
    input  logic              en,
    input  lgm_pkg::lgm_div_t din,
    output lgm_pkg::lgm_div_t dout
);
    import lgm_pkg::*;

    logic [BW:0]  trial;
    logic         ge;
    logic [BW:0]  diff;
    lgm_div_t     step;

    // One restoring step: pull the top dividend bit into the remainder
    always_comb
    begin
        trial     = {din.rem, din.x[XW-1]};
        ge        = (trial >= {1'b0, din.dvs});
        diff      = trial - {1'b0, din.dvs};
        step.rem  = ge ? diff[BW-1:0] : trial[BW-1:0];
        step.x    = {din.x[XW-2:0], ge};
        step.dvs  = din.dvs;
    end

    // Hand on to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
            dout <= step;
    end

endmodule

@@ rtl/loop_nest_lane_group_mapper.sv @@
// Loop-nest lane-group mapper.
// Input channel (in_valid / in_stall) carries group_index, lane_index and
// done_iters; the result channel (out_valid / out_stall) returns the group
// count, the lane's loop coordinates and flat index, and the current group
// with its iteration count. Exactly one result beat per input beat.
// Throughput: one beat per cycle while out_stall does not hold the pipeline.
// The pipeline depth is set by the rows of division cells (16 steps for the
// chunk count, then two rows of 54 steps each) plus six registered stages
// after the input register.
// Bounds and lane count sit in a write port (cfg_we, cfg_index, cfg_data);
// write them only while no beat is in flight.
// Reset clears every stage valid and the output valid, and loads bounds of
// one, one lane and multi-dimensional mode.
// While out_valid is high and out_stall is high, the whole pipeline holds
// and in_stall is raised; the held result does not change.
module loop_nest_lane_group_mapper (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [lgm_pkg::IDXW-1:0] cfg_index,
    input  logic [lgm_pkg::BW-1:0]   cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [lgm_pkg::GW-1:0]   group_index,
    input  logic [lgm_pkg::LNW-1:0]  lane_index,
    input  logic [lgm_pkg::GW-1:0]   done_iters,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [lgm_pkg::GW-1:0]   group_total,
    output logic [lgm_pkg::C0W-1:0]  coord_inner,
    output logic [lgm_pkg::BW-1:0]   coord_middle,
    output logic [lgm_pkg::GW-1:0]   coord_outer,
    output logic [lgm_pkg::FW-1:0]   flat_iteration,
    output logic [lgm_pkg::GW-1:0]   current_group,
    output logic [lgm_pkg::LW-1:0]   current_group_iters
);
    import lgm_pkg::*;

    typedef struct packed {
        logic [GW-1:0]  g;
        logic [LNW-1:0] lane;
        logic [GW-1:0]  done;
    } in_t;

    typedef struct packed {
        logic [GW-1:0]  g;
        logic [LNW-1:0] lane;
        logic [FW-1:0]  flat;
        logic [GW-1:0]  prod;
        logic [GW-1:0]  dval;
    } front_t;

    typedef struct packed {
        logic [GW-1:0]   g;
        logic [LNW-1:0]  lane;
        logic [FW-1:0]   flat;
        logic [GW-1:0]   total;
        logic [GW-1:0]   d;
        logic [BW-1:0]   chunks;
        logic [2*BW-1:0] b12;
    } mid_t;

    typedef struct packed {
        logic [GW-1:0]  gtotal;
        logic [C0W-1:0] c0;
        logic [FW-1:0]  flat;
        logic [XW-1:0]  q;
        logic [GW-1:0]  curm;
        logic [BW-1:0]  off;
        logic [LW-1:0]  iters;
    } tail_t;

    typedef struct packed {
        logic [GW-1:0]  gtotal;
        logic [C0W-1:0] c0;
        logic [BW-1:0]  c1;
        logic [GW-1:0]  c2;
        logic [FW-1:0]  flat;
        logic [GW-1:0]  cur;
        logic [LW-1:0]  iters;
    } out_t;

    cfg_t             cfg;
    logic             en;
    logic [BW-1:0]    lx;
    logic [NSTG-1:0]  vld_reg, vld_next;
    logic             out_valid_reg;

    in_t              r1_reg;
    front_t           r2_reg, r2_next;
    front_t           r3_reg, r3_next;
    front_t           r4_reg, r4_next;
    mid_t             r5_reg, r5_next;
    tail_t            r7_reg, r7_next;
    out_t             out_reg, out_next;

    front_t           sa_reg [NA];
    mid_t             sb_reg [NB];
    tail_t            sc_reg [NC];

    lgm_div_t         ca [NA+1];
    lgm_div_t         cba [NB+1];
    lgm_div_t         cbc [NB+1];
    lgm_div_t         cbe [NB+1];
    lgm_div_t         ccb [NC+1];
    lgm_div_t         ccd [NC+1];

    logic [GW+LW-1:0] gl;
    logic [2*BW-1:0]  b01;
    logic [GW-1:0]    gt_m;
    logic [BW+LW-1:0] rl;
    logic [BW+LW-1:0] c0_sum;
    logic [GW+BW-1:0] cm;
    logic [GW-1:0]    left;
    logic [BW-1:0]    room;
    logic [BW-1:0]    lim;

    lgm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    assign lx       = {{(BW-LW){1'b0}}, cfg.lanes};
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Advance the valid line
    assign vld_next = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[NSTG-1];
        end
    end

    // Flat index and first bound product
    always_comb
    begin
        gl           = r1_reg.g * cfg.lanes;
        b01          = cfg.b0 * cfg.b1;
        r2_next.g    = r1_reg.g;
        r2_next.lane = r1_reg.lane;
        r2_next.flat = gl[FW-1:0] + FW'(r1_reg.lane);
        r2_next.prod = GW'(b01);
        r2_next.dval = r1_reg.done;
    end

    // Total iteration count
    always_comb
    begin
        r3_next      = r2_reg;
        r3_next.prod = r2_reg.prod[2*BW-1:0] * cfg.b2;
    end

    // Clamp the completed count to the total
    always_comb
    begin
        r4_next      = r3_reg;
        r4_next.dval = (r3_reg.dval > r3_reg.prod) ? r3_reg.prod : r3_reg.dval;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg <= '{g: group_index, lane: lane_index, done: done_iters};
            r2_reg <= r2_next;
            r3_reg <= r3_next;
            r4_reg <= r4_next;
        end
    end

    // Chunk count: inner bound over lanes
    always_comb
    begin
        ca[0].x   = {cfg.b0, {(XW-BW){1'b0}}};
        ca[0].rem = '0;
        ca[0].dvs = lx;
    end

    for (genvar k = 0; k < NA; k++)
    begin : g_ca
        lgm_div_cell u_cell (.clk(clk), .en(en), .din(ca[k]), .dout(ca[k+1]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg[0] <= r4_reg;
            for (int i = 1; i < NA; i++)
                sa_reg[i] <= sa_reg[i-1];
        end
    end

    // Round the chunk count up, form the bound product for the group count
    always_comb
    begin
        r5_next.g      = sa_reg[NA-1].g;
        r5_next.lane   = sa_reg[NA-1].lane;
        r5_next.flat   = sa_reg[NA-1].flat;
        r5_next.total  = sa_reg[NA-1].prod;
        r5_next.d      = sa_reg[NA-1].dval;
        r5_next.chunks = ca[NA].x[BW-1:0] + BW'(ca[NA].rem != '0);
        r5_next.b12    = cfg.b1 * cfg.b2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r5_reg <= r5_next;
    end

    // First row: group split, completed-count split, group count
    always_comb
    begin
        cba[0].x   = cfg.flatten ? r5_reg.flat : XW'(r5_reg.g);
        cba[0].rem = '0;
        cba[0].dvs = cfg.flatten ? cfg.b0 : r5_reg.chunks;
        cbc[0].x   = XW'(r5_reg.d);
        cbc[0].rem = '0;
        cbc[0].dvs = cfg.flatten ? lx : cfg.b0;
        cbe[0].x   = XW'(r5_reg.total);
        cbe[0].rem = '0;
        cbe[0].dvs = lx;
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_cb
        lgm_div_cell u_cell_a (.clk(clk), .en(en), .din(cba[k]), .dout(cba[k+1]));
        lgm_div_cell u_cell_c (.clk(clk), .en(en), .din(cbc[k]), .dout(cbc[k+1]));
        lgm_div_cell u_cell_e (.clk(clk), .en(en), .din(cbe[k]), .dout(cbe[k+1]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= r5_reg;
            for (int i = 1; i < NB; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // Group count, inner coordinate, current group base, iterations left
    always_comb
    begin
        gt_m   = sb_reg[NB-1].b12 * sb_reg[NB-1].chunks;
        rl     = cba[NB].rem * cfg.lanes;
        c0_sum = rl + (BW+LW)'(sb_reg[NB-1].lane);
        cm     = cbc[NB].x[GW-1:0] * sb_reg[NB-1].chunks;
        left   = sb_reg[NB-1].total - sb_reg[NB-1].d;
        room   = cfg.b0 - cbc[NB].rem;

        if (cfg.flatten)
            lim = lx;
        else
            lim = (room < lx) ? room : lx;

        r7_next.flat = sb_reg[NB-1].flat;
        r7_next.q    = cba[NB].x;
        r7_next.off  = cbc[NB].rem;

        if (cfg.flatten)
        begin
            r7_next.gtotal = cbe[NB].x[GW-1:0] + GW'(cbe[NB].rem != '0);
            r7_next.c0     = C0W'(cba[NB].rem);
            r7_next.curm   = cbc[NB].x[GW-1:0];
        end
        else
        begin
            r7_next.gtotal = gt_m;
            r7_next.c0     = c0_sum[C0W-1:0];
            r7_next.curm   = cm[GW-1:0];
        end

        if (left == '0)
            r7_next.iters = '0;
        else if (left < GW'(lim))
            r7_next.iters = left[LW-1:0];
        else
            r7_next.iters = lim[LW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r7_reg <= r7_next;
    end

    // Second row: middle/outer split, offset over lanes
    always_comb
    begin
        ccb[0].x   = r7_reg.q;
        ccb[0].rem = '0;
        ccb[0].dvs = cfg.b1;
        ccd[0].x   = XW'(r7_reg.off);
        ccd[0].rem = '0;
        ccd[0].dvs = lx;
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_cc
        lgm_div_cell u_cell_b (.clk(clk), .en(en), .din(ccb[k]), .dout(ccb[k+1]));
        lgm_div_cell u_cell_d (.clk(clk), .en(en), .din(ccd[k]), .dout(ccd[k+1]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg[0] <= r7_reg;
            for (int i = 1; i < NC; i++)
                sc_reg[i] <= sc_reg[i-1];
        end
    end

    // Assemble the result beat
    always_comb
    begin
        out_next.gtotal = sc_reg[NC-1].gtotal;
        out_next.c0     = sc_reg[NC-1].c0;
        out_next.c1     = ccb[NC].rem;
        out_next.c2     = ccb[NC].x[GW-1:0];
        out_next.flat   = sc_reg[NC-1].flat;
        out_next.iters  = sc_reg[NC-1].iters;
        if (cfg.flatten)
            out_next.cur = sc_reg[NC-1].curm;
        else
            out_next.cur = sc_reg[NC-1].curm + ccd[NC].x[GW-1:0];
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid           = out_valid_reg;
    assign group_total         = out_reg.gtotal;
    assign coord_inner         = out_reg.c0;
    assign coord_middle        = out_reg.c1;
    assign coord_outer         = out_reg.c2;
    assign flat_iteration      = out_reg.flat;
    assign current_group       = out_reg.cur;
    assign current_group_iters = out_reg.iters;

endmodule

@@ rtl/lgm_checker.sv @@
`include "loop_nest_lane_group_mapper_assert.svh"

module lgm_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [lgm_pkg::GW-1:0]  group_total,
    input logic [lgm_pkg::GW-1:0]  current_group,
    input logic [lgm_pkg::LW-1:0]  current_group_iters
);
    import lgm_pkg::*;

    // Back-pressure comes only from a held result
    `LGM_ASSERT_SAME(a_stall_src, 1'b1, in_stall == (out_valid && out_stall))

    // A stalled beat stays put
    `LGM_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(group_total) && $stable(current_group))

    // A group never runs more than the lane maximum
    `LGM_ASSERT_SAME(a_iters, out_valid, current_group_iters <= LW'(MAX_LANES))

endmodule

bind loop_nest_lane_group_mapper lgm_checker u_lgm_checker (.*);
